[hdl/pfe_pkg.sv]
package pfe_pkg;

    // Palette geometry.
    localparam int ENTRIES = 64;
    localparam int AW = $clog2(ENTRIES);
    localparam int IDX_W = 6;
    localparam int COLOR_W = 12;
    localparam int SPEED_W = 8;

    typedef logic [AW-1:0] addr_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [SPEED_W-1:0] speed_t;

    localparam addr_t LAST_ADDR = addr_t'(ENTRIES - 1);

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_WR_CUR = 2'd1,
        OP_WR_TGT = 2'd2,
        OP_START  = 2'd3
    } opcode_t;

    // Color field masks and one-unit increments (red, green, blue).
    localparam color_t MASK_R = 12'h00E;
    localparam color_t MASK_G = 12'h0E0;
    localparam color_t MASK_B = 12'hE00;
    localparam color_t UNIT_R = 12'h002;
    localparam color_t UNIT_G = 12'h020;
    localparam color_t UNIT_B = 12'h200;

endpackage

[hdl/pfe_ram.sv]
module pfe_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port (read-before-write).
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/pfe_step.sv]
module pfe_step (
    input  pfe_pkg::color_t cur,
    input  pfe_pkg::color_t tgt,
    output pfe_pkg::color_t nxt,
    output logic            changed
);

    // Returns {moved, delta}; delta is +unit, -unit or zero in modulo arithmetic.
    function automatic logic [pfe_pkg::COLOR_W:0] field_delta(
        input pfe_pkg::color_t c_word,
        input pfe_pkg::color_t t_word,
        input pfe_pkg::color_t mask,
        input pfe_pkg::color_t unit
    );
        pfe_pkg::color_t c;
        pfe_pkg::color_t t;
        c = c_word & mask;
        t = t_word & mask;
        if (c < t)
        begin
            return {1'b1, unit};
        end
        else if (c > t)
        begin
            return {1'b1, pfe_pkg::color_t'(~unit + 12'd1)};
        end
        return '0;
    endfunction

    logic [pfe_pkg::COLOR_W:0] d_r;
    logic [pfe_pkg::COLOR_W:0] d_g;
    logic [pfe_pkg::COLOR_W:0] d_b;

    // Each field moves one unit toward its target; fields never carry into each other.
    always_comb
    begin
        d_r = field_delta(cur, tgt, pfe_pkg::MASK_R, pfe_pkg::UNIT_R);
        d_g = field_delta(cur, tgt, pfe_pkg::MASK_G, pfe_pkg::UNIT_G);
        d_b = field_delta(cur, tgt, pfe_pkg::MASK_B, pfe_pkg::UNIT_B);
        nxt = cur + d_r[pfe_pkg::COLOR_W-1:0] + d_g[pfe_pkg::COLOR_W-1:0]
            + d_b[pfe_pkg::COLOR_W-1:0];
        changed = d_r[pfe_pkg::COLOR_W] | d_g[pfe_pkg::COLOR_W] | d_b[pfe_pkg::COLOR_W];
    end

endmodule

[hdl/palette_fade_engine.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// request  | in_valid / in_ready    | opcode, entry_index, color_value
// result   | out_valid / out_ready  | still_fading, color_valid, out_index, out_color, last
// config   | cfg_wr_en (no wait)    | cfg_wr_data (fade_speed)
//
// Writes, fade start and ticks that do not step are answered from the idle state.
// A stepping tick makes one read-modify-write pass over the current palette RAM,
// one entry per cycle over all 64 entries, then, if any color moved, a second pass
// reading one entry per cycle into the result register.
// A step that changes nothing ends the fade with one status result.
// Reset clears per-entry valid bits at once (invalid entries read as zero), so
// there is no clearing pass. A stalled result holds the pass in place.
module palette_fade_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  pfe_pkg::speed_t        cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  pfe_pkg::idx_t          entry_index,
    input  pfe_pkg::color_t        color_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   still_fading,
    output logic                   color_valid,
    output pfe_pkg::idx_t          out_index,
    output pfe_pkg::color_t        out_color,
    output logic                   last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    pfe_pkg::addr_t                  addr_reg, addr_next;
    logic                            changed_reg, changed_next;
    logic                            fade_active_reg, fade_active_next;
    pfe_pkg::speed_t                 tick_counter_reg, tick_counter_next;
    pfe_pkg::speed_t                 fade_speed_reg;
    logic [pfe_pkg::ENTRIES-1:0]     cur_vld_reg;
    logic [pfe_pkg::ENTRIES-1:0]     tgt_vld_reg;
    logic                            cur_vld_q_reg;
    logic                            tgt_vld_q_reg;

    logic                            out_valid_reg, out_valid_next;
    logic                            still_fading_reg, still_fading_next;
    logic                            color_valid_reg, color_valid_next;
    pfe_pkg::idx_t                   out_index_reg, out_index_next;
    pfe_pkg::color_t                 out_color_reg, out_color_next;
    logic                            last_reg, last_next;

    logic                            slot_free;
    logic                            accept;
    logic                            in_range;
    pfe_pkg::opcode_t                op;
    pfe_pkg::addr_t                  in_addr;
    pfe_pkg::speed_t                 cnt_inc;

    logic                            cur_we;
    pfe_pkg::addr_t                  cur_waddr;
    pfe_pkg::color_t                 cur_wdata;
    logic                            tgt_we;
    pfe_pkg::color_t                 cur_rdata;
    pfe_pkg::color_t                 tgt_rdata;
    pfe_pkg::color_t                 cur_eff;
    pfe_pkg::color_t                 tgt_eff;
    pfe_pkg::color_t                 step_nxt;
    logic                            step_chg;

    // Palette memories, read at the address the sequencer holds next cycle.
    pfe_ram #(
        .WIDTH (pfe_pkg::COLOR_W),
        .DEPTH (pfe_pkg::ENTRIES)
    ) u_cur_ram (
        .clk     (clk),
        .wr_en   (cur_we),
        .wr_addr (cur_waddr),
        .wr_data (cur_wdata),
        .rd_addr (addr_next),
        .rd_data (cur_rdata)
    );

    pfe_ram #(
        .WIDTH (pfe_pkg::COLOR_W),
        .DEPTH (pfe_pkg::ENTRIES)
    ) u_tgt_ram (
        .clk     (clk),
        .wr_en   (tgt_we),
        .wr_addr (in_addr),
        .wr_data (color_value),
        .rd_addr (addr_next),
        .rd_data (tgt_rdata)
    );

    // Entries never written read as zero.
    assign cur_eff = cur_vld_q_reg ? cur_rdata : '0;
    assign tgt_eff = tgt_vld_q_reg ? tgt_rdata : '0;

    pfe_step u_step (
        .cur     (cur_eff),
        .tgt     (tgt_eff),
        .nxt     (step_nxt),
        .changed (step_chg)
    );

    // Request side decode.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign op        = pfe_pkg::opcode_t'(opcode);
    assign in_addr   = pfe_pkg::addr_t'(entry_index);
    assign in_range  = 32'(entry_index) < 32'(pfe_pkg::ENTRIES);
    assign cnt_inc   = tick_counter_reg + 8'd1;

    // Sequencer next-state and result register loading.
    always_comb
    begin
        state_next        = state_reg;
        addr_next         = addr_reg;
        changed_next      = changed_reg;
        fade_active_next  = fade_active_reg;
        tick_counter_next = tick_counter_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        still_fading_next = still_fading_reg;
        color_valid_next  = color_valid_reg;
        out_index_next    = out_index_reg;
        out_color_next    = out_color_reg;
        last_next         = last_reg;
        cur_we            = 1'b0;
        cur_waddr         = in_addr;
        cur_wdata         = color_value;
        tgt_we            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                addr_next    = '0;
                changed_next = 1'b0;
                if (accept)
                begin
                    // Default reply is a status result.
                    out_valid_next    = 1'b1;
                    still_fading_next = fade_active_reg;
                    color_valid_next  = 1'b0;
                    out_index_next    = '0;
                    out_color_next    = '0;
                    last_next         = 1'b1;
                    case (op)
                        pfe_pkg::OP_WR_CUR:
                        begin
                            if (in_range)
                            begin
                                cur_we           = 1'b1;
                                color_valid_next = 1'b1;
                                out_index_next   = entry_index;
                                out_color_next   = color_value;
                            end
                        end
                        pfe_pkg::OP_WR_TGT:
                        begin
                            tgt_we = in_range;
                        end
                        pfe_pkg::OP_START:
                        begin
                            fade_active_next  = 1'b1;
                            tick_counter_next = '0;
                            still_fading_next = 1'b1;
                        end
                        default:
                        begin
                            if (fade_active_reg)
                            begin
                                if (cnt_inc < fade_speed_reg)
                                begin
                                    tick_counter_next = cnt_inc;
                                end
                                else
                                begin
                                    tick_counter_next = '0;
                                    out_valid_next    = 1'b0;
                                    state_next        = ST_STEP;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                // Read-modify-write of one entry per cycle.
                cur_we       = 1'b1;
                cur_waddr    = addr_reg;
                cur_wdata    = step_nxt;
                changed_next = changed_reg | step_chg;
                if (addr_reg == pfe_pkg::LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = changed_next ? ST_EMIT : ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                // Send one stepped entry whenever the result register is free.
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    still_fading_next = 1'b1;
                    color_valid_next  = 1'b1;
                    out_index_next    = pfe_pkg::idx_t'(addr_reg);
                    out_color_next    = cur_eff;
                    last_next         = addr_reg == pfe_pkg::LAST_ADDR;
                    if (addr_reg == pfe_pkg::LAST_ADDR)
                    begin
                        addr_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                // Nothing moved: the fade ends with one status result.
                if (slot_free)
                begin
                    fade_active_next  = 1'b0;
                    out_valid_next    = 1'b1;
                    still_fading_next = 1'b0;
                    color_valid_next  = 1'b0;
                    out_index_next    = '0;
                    out_color_next    = '0;
                    last_next         = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, registered outputs, valid bits and the speed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            addr_reg         <= '0;
            changed_reg      <= 1'b0;
            fade_active_reg  <= 1'b0;
            tick_counter_reg <= '0;
            fade_speed_reg   <= '0;
            cur_vld_reg      <= '0;
            tgt_vld_reg      <= '0;
            cur_vld_q_reg    <= 1'b0;
            tgt_vld_q_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            still_fading_reg <= 1'b0;
            color_valid_reg  <= 1'b0;
            out_index_reg    <= '0;
            out_color_reg    <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            changed_reg      <= changed_next;
            fade_active_reg  <= fade_active_next;
            tick_counter_reg <= tick_counter_next;
            if (cfg_wr_en)
            begin
                fade_speed_reg <= cfg_wr_data;
            end
            if (cur_we)
            begin
                cur_vld_reg[cur_waddr] <= 1'b1;
            end
            if (tgt_we)
            begin
                tgt_vld_reg[in_addr] <= 1'b1;
            end
            cur_vld_q_reg    <= cur_vld_reg[addr_next];
            tgt_vld_q_reg    <= tgt_vld_reg[addr_next];
            out_valid_reg    <= out_valid_next;
            still_fading_reg <= still_fading_next;
            color_valid_reg  <= color_valid_next;
            out_index_reg    <= out_index_next;
            out_color_reg    <= out_color_next;
            last_reg         <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign still_fading = still_fading_reg;
    assign color_valid  = color_valid_reg;
    assign out_index    = out_index_reg;
    assign out_color    = out_color_reg;
    assign last         = last_reg;

    // The emit pass only runs as part of an active fade.
    a_emit_fading: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> fade_active_reg)
        else $error("emit pass without an active fade");

    // The step pass never produces a result.
    a_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) && !out_valid_reg |=> !out_valid_reg)
        else $error("result produced during the step pass");

    // Each accepted emit slot advances to the next entry.
    a_emit_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && slot_free && (addr_reg != pfe_pkg::LAST_ADDR)
        |=> (state_reg == ST_EMIT) && (addr_reg == $past(addr_reg) + 1'b1))
        else $error("emit pass skipped or repeated an entry");

endmodule

[verif/palette_fade_engine_tb.sv]
module palette_fade_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLDOFF_CYCLES = 2000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS = 88;

    typedef struct {
        pfe_pkg::opcode_t op;
        pfe_pkg::idx_t    index;
        pfe_pkg::color_t  color;
    } palette_request_t;

    typedef struct {
        logic            still_fading;
        logic            color_valid;
        pfe_pkg::idx_t   index;
        pfe_pkg::color_t color;
        logic            last;
    } palette_result_t;

    // Block ports.
    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_wr_en = 1'b0;
    pfe_pkg::speed_t cfg_wr_data = '0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    logic [1:0] opcode = pfe_pkg::OP_TICK;
    pfe_pkg::idx_t   entry_index = '0;
    pfe_pkg::color_t color_value = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    logic    still_fading;
    logic    color_valid;
    pfe_pkg::idx_t   out_index;
    pfe_pkg::color_t out_color;
    logic    last;

    // Stimulus and scoreboard state.
    palette_request_t pending_requests[$];
    palette_result_t  expected_results[$];
    palette_request_t driver_req;
    palette_result_t  got_result;
    palette_result_t  want_result;
    int unsigned requests_queued = 0;
    int unsigned requests_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        holdoff_go = 1'b0;
    int          holdoff_count = 0;

    // Shadow copy of the palette engine state.
    pfe_pkg::color_t current_shadow [pfe_pkg::ENTRIES] = '{default: '0};
    pfe_pkg::color_t target_shadow [pfe_pkg::ENTRIES] = '{default: '0};
    logic   fading_shadow = 1'b0;
    pfe_pkg::speed_t tick_shadow = '0;
    pfe_pkg::speed_t speed_shadow = '0;

    palette_fade_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .entry_index  (entry_index),
        .color_value  (color_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .still_fading (still_fading),
        .color_valid  (color_valid),
        .out_index    (out_index),
        .out_color    (out_color),
        .last         (last)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Move one color field one unit toward its goal value.
    function automatic pfe_pkg::color_t nudge_field(pfe_pkg::color_t word,
                                                    pfe_pkg::color_t goal,
                                                    pfe_pkg::color_t mask,
                                                    pfe_pkg::color_t unit);
        if ((word & mask) < (goal & mask))
            return word + unit;
        if ((word & mask) > (goal & mask))
            return word - unit;
        return word;
    endfunction

    function automatic palette_result_t make_result(logic valid, pfe_pkg::idx_t index,
                                                    pfe_pkg::color_t color,
                                                    logic is_last);
        palette_result_t r;
        r.still_fading = fading_shadow;
        r.color_valid = valid;
        r.index = index;
        r.color = color;
        r.last = is_last;
        return r;
    endfunction

    // Update the shadow state for one accepted request and queue its results.
    task automatic predict_palette_request(palette_request_t req);
        pfe_pkg::color_t stepped;
        logic   moved;
        logic   status_only;
        int     i;
        moved = 1'b0;
        status_only = 1'b1;
        case (req.op)
            pfe_pkg::OP_WR_CUR:
            begin
                current_shadow[req.index] = req.color;
                expected_results.push_back(make_result(1'b1, req.index, req.color, 1'b1));
                status_only = 1'b0;
            end
            pfe_pkg::OP_WR_TGT:
            begin
                target_shadow[req.index] = req.color;
            end
            pfe_pkg::OP_START:
            begin
                fading_shadow = 1'b1;
                tick_shadow = '0;
            end
            default:
            begin
                if (fading_shadow)
                begin
                    tick_shadow = tick_shadow + 1'b1;
                    if (tick_shadow >= speed_shadow)
                    begin
                        tick_shadow = '0;
                        for (i = 0; i < pfe_pkg::ENTRIES; i++)
                        begin
                            stepped = nudge_field(current_shadow[i], target_shadow[i],
                                                  pfe_pkg::MASK_R, pfe_pkg::UNIT_R);
                            stepped = nudge_field(stepped, target_shadow[i],
                                                  pfe_pkg::MASK_G, pfe_pkg::UNIT_G);
                            stepped = nudge_field(stepped, target_shadow[i],
                                                  pfe_pkg::MASK_B, pfe_pkg::UNIT_B);
                            if (stepped != current_shadow[i])
                                moved = 1'b1;
                            current_shadow[i] = stepped;
                        end
                        if (!moved)
                            fading_shadow = 1'b0;
                        else
                        begin
                            for (i = 0; i < pfe_pkg::ENTRIES; i++)
                                expected_results.push_back(make_result(1'b1,
                                    pfe_pkg::idx_t'(i), current_shadow[i],
                                    i == pfe_pkg::ENTRIES - 1));
                            status_only = 1'b0;
                        end
                    end
                end
            end
        endcase
        if (status_only)
            expected_results.push_back(make_result(1'b0, '0, '0, 1'b1));
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Request driver: presents queued requests, idling at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                driver_req = pending_requests.pop_front();
                in_valid <= 1'b1;
                opcode <= driver_req.op;
                entry_index <= driver_req.index;
                color_value <= driver_req.color;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: one long hold-off when asked, otherwise random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (holdoff_go && holdoff_count < HOLDOFF_CYCLES)
        begin
            out_ready <= 1'b0;
            holdoff_count <= holdoff_count + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: tracks the speed register, predicts on each request, checks each result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                speed_shadow = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                predict_palette_request(palette_request_t'{pfe_pkg::opcode_t'(opcode),
                                                           entry_index, color_value});
                requests_accepted++;
            end
            if (out_valid && out_ready)
            begin
                got_result = '{still_fading, color_valid, out_index, out_color, last};
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result expected none, actual index %0d color %03h",
                             $time, out_index, out_color);
                    mismatch_count++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    compare_field("still_fading", 32'(want_result.still_fading),
                                  32'(got_result.still_fading));
                    compare_field("color_valid", 32'(want_result.color_valid),
                                  32'(got_result.color_valid));
                    compare_field("out_index", 32'(want_result.index),
                                  32'(got_result.index));
                    compare_field("out_color", 32'(want_result.color),
                                  32'(got_result.color));
                    compare_field("last", 32'(want_result.last), 32'(got_result.last));
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_request(pfe_pkg::opcode_t op, int index, int color);
        pending_requests.push_back(palette_request_t'{op, pfe_pkg::idx_t'(index),
                                                      pfe_pkg::color_t'(color)});
        requests_queued++;
    endtask

    // Write the speed register while the block is idle.
    task automatic write_speed(pfe_pkg::speed_t value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (requests_accepted != requests_queued || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Mostly complete fades: target and current writes, a start, then enough ticks
    // to walk one to nine steps. The rest is short bursts of arbitrary requests.
    task automatic fill_random_phase(int item_goal, int ticks_per_step);
        int unsigned start_count;
        int n;
        start_count = requests_queued;
        while (requests_queued - start_count < item_goal)
        begin
            if ($urandom_range(99) < 80)
            begin
                n = $urandom_range(6, 1);
                repeat (n) queue_request(pfe_pkg::OP_WR_TGT, $urandom_range(63),
                                         $urandom_range(4095));
                n = $urandom_range(4, 0);
                repeat (n) queue_request(pfe_pkg::OP_WR_CUR, $urandom_range(63),
                                         $urandom_range(4095));
                queue_request(pfe_pkg::OP_START, $urandom_range(63), $urandom_range(4095));
                n = ticks_per_step * $urandom_range(9, 1);
                repeat (n) queue_request(pfe_pkg::OP_TICK, $urandom_range(63),
                                         $urandom_range(4095));
            end
            else
            begin
                n = $urandom_range(4, 1);
                repeat (n) queue_request(pfe_pkg::opcode_t'($urandom_range(3)),
                                         $urandom_range(63), $urandom_range(4095));
            end
        end
    endtask

    initial
    begin
        int     phase;
        int     send_idle_table [4];
        int     recv_stall_table [4];
        pfe_pkg::speed_t speed_table [4];
        send_idle_table = '{0, 47, 0, 7};
        recv_stall_table = '{0, 0, 47, 7};
        speed_table = '{8'd1, 8'd0, 8'd2, 8'd4};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Speed zero: every tick steps. Full white fades to black keeping the unstepped
        // bits, 0xAAA fades up, 0x555 fades down, and an entry already at target stays.
        write_speed(8'd0);
        queue_request(pfe_pkg::OP_TICK, 0, 0);
        queue_request(pfe_pkg::OP_WR_CUR, 0, 12'hFFF);
        queue_request(pfe_pkg::OP_WR_CUR, 63, 12'hAAA);
        queue_request(pfe_pkg::OP_WR_CUR, 5, 12'h555);
        queue_request(pfe_pkg::OP_WR_TGT, 0, 12'h000);
        queue_request(pfe_pkg::OP_WR_TGT, 63, 12'hFFF);
        queue_request(pfe_pkg::OP_WR_TGT, 10, 12'h001);
        queue_request(pfe_pkg::OP_START, 0, 0);
        repeat (8) queue_request(pfe_pkg::OP_TICK, 63, 12'hFFF);
        queue_request(pfe_pkg::OP_TICK, 0, 0);
        wait_idle();

        // Speed three: two ticks below speed, a step, then a tick that only counts.
        write_speed(8'd3);
        queue_request(pfe_pkg::OP_WR_TGT, 1, 12'h0E0);
        queue_request(pfe_pkg::OP_START, 0, 0);
        repeat (4) queue_request(pfe_pkg::OP_TICK, 0, 0);
        wait_idle();

        // Maximum speed: ticks only count.
        write_speed(8'd255);
        queue_request(pfe_pkg::OP_START, 0, 0);
        repeat (3) queue_request(pfe_pkg::OP_TICK, 0, 0);
        wait_idle();

        // Random phases with different idling; the first holds results back for
        // a long stretch so the block backs up into its request side.
        for (phase = 0; phase < 4; phase++)
        begin
            write_speed(speed_table[phase]);
            send_idle_pct <= send_idle_table[phase];
            recv_stall_pct <= recv_stall_table[phase];
            if (phase == 0)
                holdoff_go <= 1'b1;
            fill_random_phase(PHASE_ITEMS,
                              (speed_table[phase] == 0) ? 1 : int'(speed_table[phase]));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
